/* design/slpbc_pkg.sv */
// Shared constants and codes for the status LED pulse and blink controller.
`default_nettype none

package slpbc_pkg;

    // LED bank and timer sizing
    localparam int LED_COUNT_C  = 6;
    localparam int PULSE_LEDS_C = 4;
    localparam int TIMER_BITS_C = 16;

    // Field widths
    localparam int OPCODE_W     = 2;
    localparam int FLAG_SEL_W   = 3;
    localparam int PULSE_SEL_W  = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 16;

    // Item kinds
    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_FLAG  = 2'd1,
        OP_PULSE = 2'd2
    } opcode_t;

    // Status flag selectors
    localparam logic [FLAG_SEL_W-1:0] FLAG_CRITICAL    = 3'd0;
    localparam logic [FLAG_SEL_W-1:0] FLAG_BOOT        = 3'd1;
    localparam logic [FLAG_SEL_W-1:0] FLAG_PAIRING     = 3'd2;
    localparam logic [FLAG_SEL_W-1:0] FLAG_CONNECTED   = 3'd3;
    localparam logic [FLAG_SEL_W-1:0] FLAG_LISTENING   = 3'd4;
    localparam logic [FLAG_SEL_W-1:0] FLAG_READY       = 3'd5;
    localparam logic [FLAG_SEL_W-1:0] FLAG_PAIR_PHASE  = 3'd6;
    localparam int                    STATUS_FLAGS_W   = 6;

    // Fixed LED positions
    localparam int LISTEN_LED = 3;
    localparam int BLINK_LED  = 4;
    localparam int PAIR_LED   = 5;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_HOST_ROLE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE_LEN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BLINK_HALF  = 2'd2;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] PULSE_LEN_RESET  = 16'd50;
    localparam logic [CFG_DATA_W-1:0] BLINK_HALF_RESET = 16'd500;

endpackage

`default_nettype wire

/* design/status_led_pulse_blink_controller.sv */
// Status LED controller: flag, pulse and blink state with a registered result item.
//
// Usage:
//   The s_ channel takes one item per handshake: a 1 ms tick, a status flag
//   write or an activity pulse request (kind in s_tuser). Each accepted item
//   yields exactly one result item on the m_ channel with the six LED levels
//   and a mask of the levels that changed since the previous result.
//   The cfg_ channel writes host_role, pulse_length_ms and
//   blink_half_period_ms; write it only while the block is idle.
//   The output register loads at the accepting edge and the result is offered
//   in the next cycle. Throughput is one item per cycle while results are
//   taken; the state update and level logic sit between the state registers
//   and the output register.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken; a result taken in the same cycle lets
//   the next item in.
//   Reset (aresetn low, synchronous) sets the boot flag, clears pulses and
//   pairing phase, lights the blink phase, empties the output register and
//   restores the configuration defaults. The first result marks all six
//   LEDs as changed.
`default_nettype none

module status_led_pulse_blink_controller
    import slpbc_pkg::*;
#(
    parameter int PULSE_LEDS = PULSE_LEDS_C,
    parameter int TIMER_BITS = TIMER_BITS_C
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Input items
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    input  wire logic [S_TDATA_W-1:0]    s_tdata,   // [2:0] flag_select, [3] flag_value,
                                                    // [5:4] pulse_led, [7:6] zero
    input  wire logic [OPCODE_W-1:0]     s_tuser,   // [1:0] opcode
    // Result items
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [M_TDATA_W-1:0]         m_tdata,   // [5:0] led_levels, [11:6] changed_mask,
                                                    // [15:12] zero
    // Configuration writes
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int WIDE_W = (TIMER_BITS > CFG_DATA_W) ? TIMER_BITS : CFG_DATA_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    typedef logic [TIMER_BITS-1:0] timer_t;

    // Configuration registers
    logic                  host_role_reg;
    logic [CFG_DATA_W-1:0] pulse_len_reg;
    logic [CFG_DATA_W-1:0] blink_half_reg;

    // Controller state
    logic [STATUS_FLAGS_W-1:0] flags_reg, flags_next;
    logic                      phase_on_reg, phase_on_next;
    logic [PULSE_LEDS-1:0]     pulse_on_reg, pulse_on_next;
    timer_t                    pulse_rem_reg [PULSE_LEDS];
    timer_t                    pulse_rem_next [PULSE_LEDS];
    logic                      blink_on_reg, blink_on_next;
    timer_t                    blink_elapsed_reg, blink_elapsed_next;
    logic [LED_COUNT_C-1:0]    prev_levels_reg;
    logic                      prev_valid_reg;

    // Output register
    logic                      m_valid_reg;
    logic [LED_COUNT_C-1:0]    levels_out_reg;
    logic [LED_COUNT_C-1:0]    changed_out_reg;

    // Decoded item and derived values
    opcode_t                   opcode;
    logic [FLAG_SEL_W-1:0]     flag_select;
    logic                      flag_value;
    logic [PULSE_SEL_W-1:0]    pulse_led;
    logic                      accept;
    logic                      fault_now;
    logic                      fault_next;
    logic [WIDE_W-1:0]         pulse_len_wide;
    logic [WIDE_W-1:0]         blink_half_wide;
    timer_t                    pulse_len_t;
    timer_t                    blink_half_t;
    timer_t                    elapsed_inc;
    logic [LED_COUNT_C-1:0]    levels_next;
    logic [LED_COUNT_C-1:0]    changed_next;

    assign opcode      = opcode_t'(s_tuser);
    assign flag_select = s_tdata[2:0];
    assign flag_value  = s_tdata[3];
    assign pulse_led   = s_tdata[5:4];

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2 * LED_COUNT_C){1'b0}}, changed_out_reg, levels_out_reg};

    // Fit the configured lengths to the timer width
    assign pulse_len_wide  = WIDE_W'(pulse_len_reg);
    assign blink_half_wide = WIDE_W'(blink_half_reg);
    assign pulse_len_t     = pulse_len_wide[TIMER_BITS-1:0];
    assign blink_half_t    = blink_half_wide[TIMER_BITS-1:0];

    assign fault_now = flags_reg[FLAG_CRITICAL] || flags_reg[FLAG_BOOT];

    // Advance state for the item at the input
    always_comb begin
        flags_next         = flags_reg;
        phase_on_next      = phase_on_reg;
        pulse_on_next      = pulse_on_reg;
        pulse_rem_next     = pulse_rem_reg;
        blink_on_next      = blink_on_reg;
        blink_elapsed_next = blink_elapsed_reg;
        elapsed_inc        = blink_elapsed_reg;

        case (opcode)
            OP_TICK: begin
                for (int i = 0; i < PULSE_LEDS; i++) begin
                    if (pulse_on_reg[i]) begin
                        if (pulse_rem_reg[i] != '0) begin
                            pulse_rem_next[i] = pulse_rem_reg[i] - timer_t'(1);
                        end
                        if (pulse_rem_next[i] == '0) begin
                            pulse_on_next[i] = 1'b0;
                        end
                    end
                end
                if (fault_now) begin
                    if (blink_elapsed_reg != TIMER_MAX) begin
                        elapsed_inc = blink_elapsed_reg + timer_t'(1);
                    end
                    if (elapsed_inc >= blink_half_t) begin
                        blink_elapsed_next = '0;
                        blink_on_next      = !blink_on_reg;
                    end else begin
                        blink_elapsed_next = elapsed_inc;
                    end
                end else begin
                    blink_on_next      = 1'b1;
                    blink_elapsed_next = '0;
                end
            end
            OP_FLAG: begin
                if (flag_select inside {[FLAG_CRITICAL:FLAG_READY]}) begin
                    flags_next[flag_select] = flag_value;
                    if (!flag_value && flag_select == FLAG_PAIRING) begin
                        phase_on_next = 1'b0;
                    end
                end else if (flag_select == FLAG_PAIR_PHASE) begin
                    phase_on_next = flag_value;
                end
            end
            OP_PULSE: begin
                if (!fault_now) begin
                    for (int i = 0; i < PULSE_LEDS; i++) begin
                        if (int'(pulse_led) == i) begin
                            pulse_on_next[i]  = 1'b1;
                            pulse_rem_next[i] = pulse_len_t;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Derive LED levels and the change mask from the updated state
    always_comb begin
        fault_next  = flags_next[FLAG_CRITICAL] || flags_next[FLAG_BOOT];
        levels_next = '0;
        if (fault_next) begin
            levels_next[BLINK_LED] = blink_on_next;
        end else begin
            for (int i = 0; i < PULSE_LEDS; i++) begin
                levels_next[i] = pulse_on_next[i];
            end
            if (flags_next[FLAG_LISTENING]) begin
                levels_next[LISTEN_LED] = 1'b1;
            end
            if (host_role_reg) begin
                levels_next[BLINK_LED] = flags_next[FLAG_CONNECTED];
            end else begin
                levels_next[BLINK_LED] = flags_next[FLAG_READY];
                levels_next[PAIR_LED]  = flags_next[FLAG_PAIRING] && phase_on_next;
            end
        end
        changed_next = prev_valid_reg ? (levels_next ^ prev_levels_reg) : '1;
    end

    // Hold configuration, take writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            host_role_reg  <= 1'b0;
            pulse_len_reg  <= PULSE_LEN_RESET;
            blink_half_reg <= BLINK_HALF_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_HOST_ROLE:  host_role_reg  <= cfg_data[0];
                CFG_PULSE_LEN:  pulse_len_reg  <= cfg_data;
                CFG_BLINK_HALF: blink_half_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Commit state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg         <= STATUS_FLAGS_W'(1) << FLAG_BOOT;
            phase_on_reg      <= 1'b0;
            pulse_on_reg      <= '0;
            blink_on_reg      <= 1'b1;
            blink_elapsed_reg <= '0;
            prev_levels_reg   <= '0;
            prev_valid_reg    <= 1'b0;
            for (int i = 0; i < PULSE_LEDS; i++) begin
                pulse_rem_reg[i] <= '0;
            end
        end else if (accept) begin
            flags_reg         <= flags_next;
            phase_on_reg      <= phase_on_next;
            pulse_on_reg      <= pulse_on_next;
            pulse_rem_reg     <= pulse_rem_next;
            blink_on_reg      <= blink_on_next;
            blink_elapsed_reg <= blink_elapsed_next;
            prev_levels_reg   <= levels_next;
            prev_valid_reg    <= 1'b1;
        end
    end

    // Load the output register, drop valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            levels_out_reg  <= levels_next;
            changed_out_reg <= changed_next;
        end
    end

endmodule

`default_nettype wire

/* tb/tb_status_led_pulse_blink_controller.sv */
// Self-checking stream testbench for the status LED pulse and blink controller.
`default_nettype none

module tb_status_led_pulse_blink_controller;
    import slpbc_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [OPCODE_W-1:0]   OP_UNUSED   = 2'd3;
    localparam logic [FLAG_SEL_W-1:0] FLAG_UNUSED = 3'd7;

    localparam int RANDOM_PER_PHASE = 180;
    localparam int IDLE_PERCENT     = 31;
    localparam int QUIET_FIRST      = 400;
    localparam int QUIET_LAST       = 560;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0]    opcode;
        logic [FLAG_SEL_W-1:0]  flag_sel;
        logic                   flag_val;
        logic [PULSE_SEL_W-1:0] pulse_sel;
    } led_item_t;

    typedef struct packed {
        logic [LED_COUNT_C-1:0] levels;
        logic [LED_COUNT_C-1:0] changed;
    } led_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [OPCODE_W-1:0]    s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    led_item_t   pending_q[$];
    led_result_t expected_leds_q[$];
    logic        s_taken = 1'b0;
    int          sent_count = 0;
    int          results_checked = 0;
    int          fault_items = 0;
    int          error_count = 0;
    int          setting_count = 0;

    // Predicted block state and configuration
    logic                   cfg_host;
    logic [CFG_DATA_W-1:0]  cfg_pulse_len;
    logic [CFG_DATA_W-1:0]  cfg_blink_half;
    logic [STATUS_FLAGS_W-1:0] flags_st;
    logic                   phase_on;
    logic [PULSE_LEDS_C-1:0] pulse_on;
    logic [TIMER_BITS_C-1:0] pulse_left [PULSE_LEDS_C];
    logic                   blink_lit;
    logic [TIMER_BITS_C-1:0] blink_count;
    logic [LED_COUNT_C-1:0] last_levels;
    logic                   last_seen;

    status_led_pulse_blink_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic led_item_t make_item(input logic [OPCODE_W-1:0] op,
                                            input logic [FLAG_SEL_W-1:0] sel,
                                            input logic val,
                                            input logic [PULSE_SEL_W-1:0] led);
        led_item_t it;
        it.opcode    = op;
        it.flag_sel  = sel;
        it.flag_val  = val;
        it.pulse_sel = led;
        return it;
    endfunction

    // Mostly ticks and flag writes; fault flags are set less often than cleared
    function automatic led_item_t random_item();
        led_item_t it;
        int        pick;
        pick         = $urandom_range(0, 99);
        it.opcode    = (pick < 45) ? OP_TICK : (pick < 75) ? OP_FLAG :
                       (pick < 95) ? OP_PULSE : OP_UNUSED;
        it.flag_sel  = FLAG_SEL_W'($urandom_range(0, 7));
        if (it.flag_sel == FLAG_CRITICAL || it.flag_sel == FLAG_BOOT) begin
            it.flag_val = ($urandom_range(0, 99) < 30);
        end else begin
            it.flag_val = 1'($urandom_range(0, 1));
        end
        it.pulse_sel = PULSE_SEL_W'($urandom_range(0, 3));
        return it;
    endfunction

    // Advance the predicted state by one item and form its result
    task automatic predict_leds(input led_item_t it, output led_result_t res);
        logic                   fault;
        logic [LED_COUNT_C-1:0] lv;
        fault = flags_st[FLAG_CRITICAL] | flags_st[FLAG_BOOT];
        case (it.opcode)
            OP_TICK: begin
                for (int i = 0; i < PULSE_LEDS_C; i++) begin
                    if (pulse_on[i]) begin
                        if (pulse_left[i] != '0) pulse_left[i] = pulse_left[i] - 1'b1;
                        if (pulse_left[i] == '0) pulse_on[i] = 1'b0;
                    end
                end
                if (fault) begin
                    if (blink_count != '1) blink_count = blink_count + 1'b1;
                    if (blink_count >= cfg_blink_half) begin
                        blink_count = '0;
                        blink_lit   = ~blink_lit;
                    end
                end else begin
                    blink_lit   = 1'b1;
                    blink_count = '0;
                end
            end
            OP_FLAG: begin
                if (it.flag_sel <= FLAG_READY) begin
                    flags_st[it.flag_sel] = it.flag_val;
                    // leaving pairing also drops the pairing phase
                    if (it.flag_sel == FLAG_PAIRING && !it.flag_val) phase_on = 1'b0;
                end else if (it.flag_sel == FLAG_PAIR_PHASE) begin
                    phase_on = it.flag_val;
                end
            end
            OP_PULSE: begin
                if (!fault) begin
                    pulse_on[it.pulse_sel]   = 1'b1;
                    pulse_left[it.pulse_sel] = cfg_pulse_len;
                end
            end
            default: ;
        endcase

        fault = flags_st[FLAG_CRITICAL] | flags_st[FLAG_BOOT];
        lv    = '0;
        if (fault) begin
            lv[BLINK_LED] = blink_lit;
            fault_items++;
        end else begin
            for (int i = 0; i < PULSE_LEDS_C; i++) lv[i] = pulse_on[i];
            if (flags_st[FLAG_LISTENING]) lv[LISTEN_LED] = 1'b1;
            if (cfg_host) begin
                lv[BLINK_LED] = flags_st[FLAG_CONNECTED];
            end else begin
                lv[BLINK_LED] = flags_st[FLAG_READY];
                lv[PAIR_LED]  = flags_st[FLAG_PAIRING] & phase_on;
            end
        end
        res.levels  = lv;
        res.changed = last_seen ? (lv ^ last_levels) : '1;
        last_levels = lv;
        last_seen   = 1'b1;
    endtask

    // Check results, apply register writes and predict accepted items
    always @(posedge aclk) begin
        led_result_t exp_res;
        if (!aresetn) begin
            s_taken <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (expected_leds_q.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected result item: tdata=%h", m_tdata);
                end else begin
                    exp_res = expected_leds_q.pop_front();
                    if (m_tdata[5:0] !== exp_res.levels ||
                        m_tdata[11:6] !== exp_res.changed) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display("mismatch: levels exp %b got %b, changed exp %b got %b",
                                     exp_res.levels, m_tdata[5:0],
                                     exp_res.changed, m_tdata[11:6]);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_HOST_ROLE:  cfg_host       = cfg_data[0];
                    CFG_PULSE_LEN:  cfg_pulse_len  = cfg_data;
                    CFG_BLINK_HALF: cfg_blink_half = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_leds(make_item(s_tuser, s_tdata[2:0], s_tdata[3], s_tdata[5:4]),
                             exp_res);
                expected_leds_q.push_back(exp_res);
            end
            s_taken <= s_tvalid && s_tready;
        end
    end

    // Drive input items and result backpressure on the falling edge
    always @(negedge aclk) begin
        led_item_t it;
        logic      quiet;
        if (aresetn) begin
            quiet = (sent_count >= QUIET_FIRST && sent_count < QUIET_LAST);
            if (!s_tvalid || s_taken) begin
                if (pending_q.size() > 0 &&
                    (quiet || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    it = pending_q.pop_front();
                    s_tdata  <= {2'b00, it.pulse_sel, it.flag_val, it.flag_sel};
                    s_tuser  <= it.opcode;
                    s_tvalid <= 1'b1;
                    sent_count++;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Write all three registers back to back; hold valid between them
    task automatic write_regs(input logic host, input logic [CFG_DATA_W-1:0] plen,
                              input logic [CFG_DATA_W-1:0] half);
        logic [CFG_INDEX_W-1:0] idx [3];
        logic [CFG_DATA_W-1:0]  val [3];
        idx[0] = CFG_HOST_ROLE;  val[0] = {15'd0, host};
        idx[1] = CFG_PULSE_LEN;  val[1] = plen;
        idx[2] = CFG_BLINK_HALF; val[2] = half;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            @(negedge aclk);
        end
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || s_tvalid || expected_leds_q.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        logic                  host;
        logic [CFG_DATA_W-1:0] plen;
        logic [CFG_DATA_W-1:0] half;

        // Predicted state after reset
        cfg_host       = 1'b0;
        cfg_pulse_len  = PULSE_LEN_RESET;
        cfg_blink_half = BLINK_HALF_RESET;
        flags_st       = '0;
        flags_st[FLAG_BOOT] = 1'b1;
        phase_on       = 1'b0;
        pulse_on       = '0;
        for (int i = 0; i < PULSE_LEDS_C; i++) pulse_left[i] = '0;
        blink_lit      = 1'b1;
        blink_count    = '0;
        last_levels    = '0;
        last_seen      = 1'b0;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed items under the reset configuration, starting with the boot fault held
        pending_q.push_back(make_item(OP_TICK,  FLAG_CRITICAL, 1'b0, 2'd0));
        pending_q.push_back(make_item(OP_PULSE, FLAG_CRITICAL, 1'b0, 2'd0));
        pending_q.push_back(make_item(OP_UNUSED, FLAG_UNUSED,  1'b1, 2'd3));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_UNUSED,   1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_BOOT,     1'b0, 2'd0));
        for (int i = 0; i < PULSE_LEDS_C; i++)
            pending_q.push_back(make_item(OP_PULSE, FLAG_CRITICAL, 1'b0, PULSE_SEL_W'(i)));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_LISTENING,  1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_READY,      1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_PAIRING,    1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_PAIR_PHASE, 1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_PAIRING,    1'b0, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_PAIRING,    1'b1, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_CRITICAL,   1'b1, 2'd0));
        repeat (3) pending_q.push_back(make_item(OP_TICK, FLAG_CRITICAL, 1'b0, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_CRITICAL,   1'b0, 2'd0));
        pending_q.push_back(make_item(OP_FLAG,  FLAG_CONNECTED,  1'b1, 2'd0));
        pending_q.push_back(make_item(OP_TICK,  FLAG_CRITICAL,   1'b0, 2'd0));

        // Random phases: zero lengths, short timers, extremes, unit lengths, then a random setting
        for (int phase = 0; phase < 5; phase++) begin
            wait_drained();
            case (phase)
                0: begin host = 1'b0; plen = 16'd0;     half = 16'd0;     end
                1: begin host = 1'b1; plen = 16'd3;     half = 16'd2;     end
                2: begin host = 1'b0; plen = 16'hFFFF;  half = 16'hFFFF;  end
                3: begin host = 1'b1; plen = 16'd1;     half = 16'd1;     end
                default: begin
                    host = 1'($urandom_range(0, 1));
                    plen = CFG_DATA_W'($urandom_range(1, 12));
                    half = CFG_DATA_W'($urandom_range(1, 8));
                end
            endcase
            write_regs(host, plen, half);
            repeat (RANDOM_PER_PHASE) pending_q.push_back(random_item());
        end

        wait_drained();
        $display("Sent %0d items across %0d register settings; %0d results checked",
                 sent_count, setting_count, results_checked);
        $display("%0d results were produced with a fault held", fault_items);
        if (expected_leds_q.size() != 0) begin
            error_count += expected_leds_q.size();
            $display("%0d expected results never arrived", expected_leds_q.size());
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", error_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #400000;
        $display("timeout: stimulus or results stalled");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
